@@ hdl/ugrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ugrt_pkg
// Shared types and constants for the uniform grid ray traversal block.
// ----------------------------------------------------------------------------
package ugrt_pkg;

  localparam int GRID_X   = 16;
  localparam int GRID_Y   = 16;
  localparam int GRID_Z   = 16;
  localparam int IDX_W    = 4;
  localparam int CELL_W   = 12;
  localparam int WALK_MAX = GRID_X + GRID_Y + GRID_Z - 2;
  localparam int K_W      = 6;
  localparam int DIV_STEPS = 64;

  localparam logic signed [63:0] TINF    = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLAB,
    S_SDIV,
    S_CLIP,
    S_PNT,
    S_MUL,
    S_MULF,
    S_CELL,
    S_CDIV,
    S_INIT,
    S_WALK,
    S_MISS
  } state_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  function automatic logic [4:0] gsize(input logic [1:0] a);
    logic [4:0] g;
    case (a)
      2'd0:    g = 5'(GRID_X);
      2'd1:    g = 5'(GRID_Y);
      default: g = 5'(GRID_Z);
    endcase
    return g;
  endfunction

endpackage

@@ hdl/ugrt_div.sv @@
// ----------------------------------------------------------------------------
// ugrt_div
// Radix-2 restoring divider, one quotient bit per cycle, sign applied at end.
// ----------------------------------------------------------------------------
module ugrt_div (
  input  logic                clk,
  input  logic                rst,
  input  ugrt_pkg::div_req_t  req,
  output logic                done,
  output logic signed [63:0]  quo_out
);
  import ugrt_pkg::*;

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] den;
  logic        neg;
  logic [64:0] sh;
  logic        ge;

  assign sh = {rem, quo[63]};
  assign ge = sh >= {1'b0, den};
  assign quo_out = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
        neg  <= req.neg;
      end else if (busy) begin
        rem <= ge ? 64'(sh - {1'b0, den}) : sh[63:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/uniform_grid_ray_traversal.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_ray_traversal
// 3D DDA walk of one ray through a uniform grid over a configured scene box.
// ----------------------------------------------------------------------------
// Usage:
//   Box bounds are written on cfg_we/cfg_index/cfg_data while no ray is in
//   flight. A ray item (origin, direction, Q16.16) is taken on in_valid and
//   in_ready. Results leave on out_valid/out_ready: one per visited cell with
//   last on the final one, or a single item with missed and last set.
//   Each ray runs up to six slab divisions and three cell divisions
//   on one shared divider, plus up to three shift-add entry-point
//   multiplies; a miss skips the multiplies and the cell divisions.
//   The results of a walk leave at one per cycle while out_ready is
//   high (up to 46 results).
//   in_ready is high only while the sequencer is idle; the output register
//   lets the next ray be accepted while the last result still waits.
//   A stalled receiver holds the walk; nothing is dropped.
//   Reset (rst, synchronous) returns the box to the unit cube, empties the
//   output register and idles the sequencer.
// ----------------------------------------------------------------------------
module uniform_grid_ray_traversal (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic signed [31:0]            origin_z,
  input  logic signed [31:0]            dir_x,
  input  logic signed [31:0]            dir_y,
  input  logic signed [31:0]            dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ugrt_pkg::CELL_W-1:0]   cell_index,
  output logic signed [31:0]            exit_distance,
  output logic                          missed,
  output logic                          last
);
  import ugrt_pkg::*;

  state_t state, state_next;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [63:0] tmn [3];
  logic signed [63:0] tmx [3];
  logic signed [63:0] dt [3];
  logic signed [63:0] nxt [3];
  logic [IDX_W-1:0]   idx [3];

  logic [1:0]         ax;
  logic               hsel;
  logic signed [63:0] qlo;
  logic signed [63:0] t0r;
  logic               inside_r;
  logic signed [63:0] acc;
  logic [4:0]         mcnt;
  logic signed [63:0] preg;
  logic [K_W-1:0]     k;

  div_req_t           dreq;
  logic               ddone;
  logic signed [63:0] dquo;

  ugrt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (dreq),
    .done    (ddone),
    .quo_out (dquo)
  );

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo[0] <= '0;
      box_lo[1] <= '0;
      box_lo[2] <= '0;
      box_hi[0] <= 32'sd65536;
      box_hi[1] <= 32'sd65536;
      box_hi[2] <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: box_lo[0] <= cfg_data;
        REG_MIN_Y: box_lo[1] <= cfg_data;
        REG_MIN_Z: box_lo[2] <= cfg_data;
        REG_MAX_X: box_hi[0] <= cfg_data;
        REG_MAX_Y: box_hi[1] <= cfg_data;
        REG_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-axis helpers
  logic               ax_last;
  logic               d_zero, d_pos;
  logic signed [63:0] lo64, hi64, o64;
  logic signed [63:0] snum;
  logic signed [63:0] cnum;
  logic [4:0]         gs;

  assign ax_last = (ax == 2'd2);
  assign d_zero  = (dir[ax] == '0);
  assign d_pos   = !dir[ax][31] && !d_zero;
  assign lo64    = 64'(box_lo[ax]);
  assign hi64    = 64'(box_hi[ax]);
  assign o64     = 64'(org[ax]);
  assign gs      = gsize(ax);
  assign snum    = (((state == S_SLAB) ? lo64 : hi64) - o64) <<< 16;
  assign cnum    = (preg - lo64) * $signed({59'd0, gs});

  // clip
  logic signed [63:0] t0, t1;
  logic               miss_c, inside_c;

  always_comb begin
    t0 = tmn[0];
    t1 = tmx[0];
    if (tmn[1] > t0) t0 = tmn[1];
    if (tmn[2] > t0) t0 = tmn[2];
    if (tmx[1] < t1) t1 = tmx[1];
    if (tmx[2] < t1) t1 = tmx[2];
    miss_c   = (t0 > t1);
    inside_c = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (box_hi[a] <= box_lo[a]) miss_c = 1'b1;
      if (org[a] < box_lo[a] || org[a] > box_hi[a]) begin
        inside_c = 1'b0;
        if (dir[a] == '0) miss_c = 1'b1;
      end
    end
  end

  // entry point multiply, signed weight on the top bit of dir
  logic signed [63:0] part;
  logic signed [63:0] accq;

  assign part = t0r <<< mcnt;
  assign accq = (acc >>> 16) + ((acc[63] && acc[15:0] != '0) ? 64'sd1 : 64'sd0);

  // grid init
  logic signed [63:0] diff, dtv;
  logic [4:0]         cmul;

  always_comb begin
    diff = tmx[ax] - tmn[ax];
    case (ax)
      2'd0:    dtv = diff / GRID_X;
      2'd1:    dtv = diff / GRID_Y;
      default: dtv = diff / GRID_Z;
    endcase
    cmul = d_pos ? 5'({1'b0, idx[ax]} + 5'd1) : gs - 5'({1'b0, idx[ax]});
  end

  // walk step
  logic               go;
  logic [1:0]         wax;
  logic signed [63:0] tx;
  logic               wpos, wterm, wlast;
  logic [CELL_W-1:0]  wcell;
  logic [IDX_W-1:0]   wmax;

  always_comb begin
    go = !out_valid || out_ready;
    if (nxt[0] < nxt[1] && nxt[0] < nxt[2]) wax = 2'd0;
    else if (nxt[1] < nxt[2])               wax = 2'd1;
    else                                    wax = 2'd2;
    tx    = nxt[wax];
    wpos  = !dir[wax][31] && dir[wax] != '0;
    wmax  = IDX_W'(gsize(wax) - 5'd1);
    wterm = wpos ? (idx[wax] == wmax) : (idx[wax] == '0);
    wlast = wterm || (k == K_W'(WALK_MAX - 1));
    wcell = CELL_W'(idx[0]) + CELL_W'(GRID_X * idx[1])
          + CELL_W'(GRID_X * GRID_Y * idx[2]);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SLAB;
      S_SLAB: begin
        if (!d_zero)     state_next = S_SDIV;
        else if (ax_last) state_next = S_CLIP;
      end
      S_SDIV: if (ddone && hsel) state_next = ax_last ? S_CLIP : S_SLAB;
      S_CLIP: state_next = miss_c ? S_MISS : S_PNT;
      S_PNT:  state_next = (!inside_r && !d_zero) ? S_MUL : S_CELL;
      S_MUL:  if (mcnt == 5'd31) state_next = S_MULF;
      S_MULF: state_next = S_CELL;
      S_CELL: begin
        if (!cnum[63])    state_next = S_CDIV;
        else if (ax_last) state_next = S_INIT;
        else              state_next = S_PNT;
      end
      S_CDIV: if (ddone) state_next = ax_last ? S_INIT : S_PNT;
      S_INIT: if (ax_last) state_next = S_WALK;
      S_WALK: if (go && wlast) state_next = S_IDLE;
      S_MISS: if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = (state == S_IDLE);
    dreq.start = 1'b0;
    dreq.neg   = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    unique case (state)
      S_SLAB, S_SDIV: begin
        dreq.start = (state == S_SLAB) ? !d_zero : (ddone && !hsel);
        dreq.neg   = snum[63] ^ dir[ax][31];
        dreq.num   = snum[63] ? 64'(-snum) : 64'(snum);
        dreq.den   = dir[ax][31] ? 64'(-64'(dir[ax])) : 64'(64'(dir[ax]));
      end
      S_CELL: begin
        dreq.start = !cnum[63];
        dreq.num   = 64'(cnum);
        dreq.den   = 64'(hi64 - lo64);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_WALK || state == S_MISS) && go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ax   <= 2'd0;
        hsel <= 1'b0;
        org[0] <= origin_x;
        org[1] <= origin_y;
        org[2] <= origin_z;
        dir[0] <= dir_x;
        dir[1] <= dir_y;
        dir[2] <= dir_z;
      end
      S_SLAB: begin
        hsel <= 1'b0;
        if (d_zero) begin
          tmn[ax] <= -TINF;
          tmx[ax] <= TINF;
          ax      <= ax_last ? 2'd0 : ax + 2'd1;
        end
      end
      S_SDIV: if (ddone) begin
        if (!hsel) begin
          qlo  <= dquo;
          hsel <= 1'b1;
        end else begin
          tmn[ax] <= d_pos ? qlo : dquo;
          tmx[ax] <= d_pos ? dquo : qlo;
          ax      <= ax_last ? 2'd0 : ax + 2'd1;
        end
      end
      S_CLIP: begin
        t0r      <= t0;
        inside_r <= inside_c;
        ax       <= 2'd0;
      end
      S_PNT: begin
        acc  <= '0;
        mcnt <= '0;
        preg <= o64;
      end
      S_MUL: begin
        if (dir[ax][mcnt]) acc <= (mcnt == 5'd31) ? acc - part : acc + part;
        mcnt <= mcnt + 5'd1;
      end
      S_MULF: preg <= o64 + accq;
      S_CELL: if (cnum[63]) begin
        idx[ax] <= '0;
        ax      <= ax_last ? 2'd0 : ax + 2'd1;
      end
      S_CDIV: if (ddone) begin
        idx[ax] <= (dquo >= $signed({59'd0, gs})) ? IDX_W'(gs - 5'd1) : IDX_W'(dquo);
        ax      <= ax_last ? 2'd0 : ax + 2'd1;
      end
      S_INIT: begin
        if (d_zero) begin
          dt[ax]  <= '0;
          nxt[ax] <= TINF;
        end else begin
          dt[ax]  <= dtv;
          nxt[ax] <= tmn[ax] + dtv * $signed({59'd0, cmul});
        end
        ax <= ax_last ? 2'd0 : ax + 2'd1;
        k  <= '0;
      end
      S_WALK: if (go) begin
        cell_index    <= wcell;
        exit_distance <= (tx > SAT_MAX) ? 32'(SAT_MAX) :
                         (tx < SAT_MIN) ? 32'(SAT_MIN) : 32'(tx);
        missed        <= 1'b0;
        last          <= wlast;
        if (tx != TINF) nxt[wax] <= tx + dt[wax];
        idx[wax] <= wpos ? idx[wax] + IDX_W'(1) : idx[wax] - IDX_W'(1);
        k <= k + K_W'(1);
      end
      S_MISS: if (go) begin
        cell_index    <= '0;
        exit_distance <= '0;
        missed        <= 1'b1;
        last          <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/ugrt_chk.sv @@
// ----------------------------------------------------------------------------
// ugrt_chk
// Port-level checks for the ray traversal block, bound to the top level.
// ----------------------------------------------------------------------------
module ugrt_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ugrt_pkg::CELL_W-1:0]  cell_index,
  input logic signed [31:0]           exit_distance,
  input logic                         missed,
  input logic                         last
);
  import ugrt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_index)
      && $stable(exit_distance) && $stable(missed) && $stable(last))
    else $error("result item changed while stalled");

  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && missed |-> last && cell_index == '0 && exit_distance == '0)
    else $error("miss item malformed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

endmodule

bind uniform_grid_ray_traversal ugrt_chk u_ugrt_chk (.*);

@@ tb/sv/tb_uniform_grid_ray_traversal.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uniform_grid_ray_traversal
// Drives rays through the grid walker under several scene boxes and idle
// patterns, predicts every visited cell and exit distance, checks in order.
// ----------------------------------------------------------------------------
module tb_uniform_grid_ray_traversal;
  import ugrt_pkg::*;

  typedef struct {
    logic [CELL_W-1:0] cidx;
    logic signed [31:0] tdist;
    logic               miss;
    logic               fin;
  } cell_hit_t;

  logic clk, rst, cfg_we, in_valid, in_ready, out_valid, out_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic [CELL_W-1:0] cell_index;
  logic signed [31:0] exit_distance;
  logic missed, last;

  cell_hit_t hits_q[$];
  longint box_lo[3], box_hi[3];
  int idle_pct, stall_pct, errors, rays_sent, hits_seen, misses_seen, idle_cnt;
  bit done;

  uniform_grid_ray_traversal dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void predict_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    longint o[3], d[3], tmn[3], tmx[3], dt[3], nxt[3], idx[3], stp[3], stp_end[3];
    longint gs[3];
    longint t0, t1, q0, q1, p, c, tx;
    bit miss, in_box;
    int ax;
    cell_hit_t h;
    o[0] = ox; o[1] = oy; o[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    gs[0] = GRID_X; gs[1] = GRID_Y; gs[2] = GRID_Z;
    miss = 0;
    in_box = 1;
    for (int a = 0; a < 3; a++) begin
      if (box_hi[a] <= box_lo[a]) miss = 1;
      if (o[a] < box_lo[a] || o[a] > box_hi[a]) in_box = 0;
      if (d[a] == 0) begin
        if (o[a] < box_lo[a] || o[a] > box_hi[a]) miss = 1;
        tmn[a] = -TINF;
        tmx[a] = TINF;
      end else begin
        q0 = ((box_lo[a] - o[a]) * 65536) / d[a];
        q1 = ((box_hi[a] - o[a]) * 65536) / d[a];
        tmn[a] = d[a] > 0 ? q0 : q1;
        tmx[a] = d[a] > 0 ? q1 : q0;
      end
    end
    t0 = tmn[0];
    t1 = tmx[0];
    for (int a = 1; a < 3; a++) begin
      if (tmn[a] > t0) t0 = tmn[a];
      if (tmx[a] < t1) t1 = tmx[a];
    end
    if (miss || t0 > t1) begin
      h.cidx = 0; h.tdist = 0; h.miss = 1; h.fin = 1;
      hits_q.insert(hits_q.size(), h);
      return;
    end
    for (int a = 0; a < 3; a++) begin
      p = o[a];
      if (!in_box && d[a] != 0) p = o[a] + (t0 * d[a]) / 65536;
      c = ((p - box_lo[a]) * gs[a]) / (box_hi[a] - box_lo[a]);
      if (c < 0) c = 0;
      if (c > gs[a] - 1) c = gs[a] - 1;
      idx[a] = c;
      if (d[a] == 0) begin
        dt[a] = 0; nxt[a] = TINF; stp[a] = -1; stp_end[a] = -1;
      end else begin
        dt[a] = (tmx[a] - tmn[a]) / gs[a];
        if (d[a] > 0) begin
          nxt[a] = tmn[a] + (c + 1) * dt[a]; stp[a] = 1; stp_end[a] = gs[a];
        end else begin
          nxt[a] = tmn[a] + (gs[a] - c) * dt[a]; stp[a] = -1; stp_end[a] = -1;
        end
      end
    end
    for (int k = 0; k < WALK_MAX; k++) begin
      h.cidx = CELL_W'(idx[0] + GRID_X * idx[1] + GRID_X * GRID_Y * idx[2]);
      if (nxt[0] < nxt[1] && nxt[0] < nxt[2]) ax = 0;
      else if (nxt[1] < nxt[2]) ax = 1;
      else ax = 2;
      tx = nxt[ax];
      if (nxt[ax] != TINF) nxt[ax] += dt[ax];
      idx[ax] += stp[ax];
      h.tdist = clip32(tx);
      h.miss = 0;
      h.fin = (idx[ax] == stp_end[ax]) || (k == WALK_MAX - 1);
      hits_q.insert(hits_q.size(), h);
      if (h.fin) return;
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      idle_cnt <= 0;
      hits_seen++;
      if (missed) misses_seen++;
      if (hits_q.size() == 0) begin
        $error("unexpected result cell_index=%0d", cell_index);
        errors++;
      end else begin
        cell_hit_t e;
        e = hits_q.pop_front();
        if (cell_index !== e.cidx) begin
          $error("cell_index: expected %0d got %0d", e.cidx, cell_index); errors++;
        end
        if (exit_distance !== e.tdist) begin
          $error("exit_distance: expected %0d got %0d", e.tdist, exit_distance); errors++;
        end
        if (missed !== e.miss) begin
          $error("missed: expected %0b got %0b", e.miss, missed); errors++;
        end
        if (last !== e.fin) begin
          $error("last: expected %0b got %0b", e.fin, last); errors++;
        end
      end
    end else if (!(in_valid && in_ready)) begin
      idle_cnt <= idle_cnt + 1;
    end else begin
      idle_cnt <= 0;
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!done && idle_cnt > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    do @(posedge clk); while (!in_ready);
    predict_ray(ox, oy, oz, dx, dy, dz);
    rays_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (hits_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_box(reg_idx_t r, int v);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (r < REG_MAX_X) box_lo[r] = v;
    else box_hi[r - REG_MAX_X] = v;
  endtask

  task automatic set_box(int x0, int y0, int z0, int x1, int y1, int z1);
    write_box(REG_MIN_X, x0); write_box(REG_MIN_Y, y0); write_box(REG_MIN_Z, z0);
    write_box(REG_MAX_X, x1); write_box(REG_MAX_Y, y1); write_box(REG_MAX_Z, z1);
  endtask

  function automatic longint rand_in(longint a, longint b);
    longint r;
    r = longint'({$urandom, $urandom} >> 1);
    return a + r % (b - a + 1);
  endfunction

  // mostly rays aimed into the box, some raw noise
  task automatic random_ray();
    longint tgt[3], org[3];
    int dv[3];
    int sh;
    if ($urandom_range(99) < 15) begin
      for (int a = 0; a < 3; a++) dv[a] = ($urandom_range(7) == 0) ? 0 : $urandom;
      send_ray($urandom, $urandom, $urandom, dv[0], dv[1], dv[2]);
      return;
    end
    sh = $urandom_range(8);
    for (int a = 0; a < 3; a++) begin
      longint span;
      span = box_hi[a] - box_lo[a];
      tgt[a] = rand_in(box_lo[a], box_hi[a]);
      org[a] = $urandom_range(1) ? rand_in(box_lo[a], box_hi[a])
                                 : clip32(tgt[a] + rand_in(-4 * span, 4 * span));
      dv[a] = ($urandom_range(9) == 0) ? 0 : clip32((tgt[a] - org[a]) >>> sh);
    end
    send_ray(int'(org[0]), int'(org[1]), int'(org[2]), dv[0], dv[1], dv[2]);
  endtask

  task automatic test_unit_cube();
    send_ray(32768, 32768, 32768, 65536, 0, 0);
    send_ray(32768, 32768, 32768, -65536, 0, 0);
    send_ray(32768, 32768, 32768, 0, 65536, 0);
    send_ray(32768, 32768, 32768, 0, -65536, 0);
    send_ray(32768, 32768, 32768, 0, 0, 65536);
    send_ray(32768, 32768, 32768, 0, 0, -65536);
    send_ray(0, 0, 0, 65536, 65536, 65536);
    send_ray(65536, 65536, 65536, -65536, -65536, -65536);
    send_ray(32768, 32768, 32768, 0, 0, 0);
    send_ray(-65536, 32768, 32768, 65536, 4096, -2048);
    send_ray(32768, 131072, 32768, 65536, 0, 0);
    send_ray(-131072, -131072, -131072, -65536, -65536, -65536);
    send_ray(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_ray(32768, 32768, 32768, 32'sh7fff_ffff, 32'sh8000_0000, 1);
    send_ray(32768, 32768, 32768, 1, -1, 1);
    send_ray(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
    drain();
  endtask

  task automatic test_box_shapes();
    set_box(-524288, -524288, -524288, 524288, 524288, 524288);
    send_ray(-1048576, 1000, -2000, 65536, 3000, 5000);
    send_ray(0, 0, 0, 100, 70, -50);
    drain();
    set_box(0, 0, 0, 0, 65536, 65536);
    send_ray(0, 32768, 32768, 65536, 0, 0);
    drain();
    set_box(0, 65536, 0, 65536, 0, 65536);
    send_ray(32768, 32768, 32768, 0, 65536, 0);
    drain();
    set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_ray(0, 0, 0, 65536, -65536, 65536);
    send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    drain();
  endtask

  task automatic test_random_phase(int idle_p, int stall_p, int n);
    longint c[3], hw[3];
    idle_pct = idle_p;
    stall_pct = stall_p;
    for (int a = 0; a < 3; a++) begin
      c[a] = rand_in(-1000000, 1000000);
      hw[a] = rand_in(256, 2000000);
    end
    set_box(int'(c[0] - hw[0]), int'(c[1] - hw[1]), int'(c[2] - hw[2]),
            int'(c[0] + hw[0]), int'(c[1] + hw[1]), int'(c[2] + hw[2]));
    repeat (n) random_ray();
    drain();
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0; out_ready = 0;
    origin_x = 0; origin_y = 0; origin_z = 0; dir_x = 0; dir_y = 0; dir_z = 0;
    idle_pct = 0; stall_pct = 0; errors = 0; rays_sent = 0; hits_seen = 0;
    misses_seen = 0; idle_cnt = 0; done = 0;
    box_lo = '{0, 0, 0};
    box_hi = '{65536, 65536, 65536};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_unit_cube();
    test_box_shapes();
    test_random_phase(0, 0, 60);
    test_random_phase(72, 0, 60);
    test_random_phase(0, 72, 60);
    test_random_phase(9, 9, 40);
    test_random_phase(0, 0, 20);
    done = 1;
    $display("%0d rays over unit, wide, degenerate, inverted and full-range boxes", rays_sent);
    $display("%0d results checked, %0d of them misses", hits_seen, misses_seen);
    if (errors == 0 && hits_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
